@@ rtl/core/evt_pkg.sv @@
// shared constants, codes and types for the event flag group
package evt_pkg;

  localparam int WAITERS   = 8;
  localparam int SLOT_W    = 3;
  localparam int FLAG_BITS = 16;
  localparam int TICK_BITS = 16;

  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [FLAG_BITS-1:0] flags_t;
  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [2:0]           action_t;
  typedef logic [2:0]           kind_t;
  typedef logic [1:0]           mode_t;

  // request actions
  localparam action_t ACT_WAIT  = 3'd0;
  localparam action_t ACT_SET   = 3'd1;
  localparam action_t ACT_CLEAR = 3'd2;
  localparam action_t ACT_TICK  = 3'd3;
  localparam action_t ACT_READ  = 3'd4;

  // result kinds
  localparam kind_t KIND_MATCHED  = 3'd0;
  localparam kind_t KIND_BLOCKED  = 3'd1;
  localparam kind_t KIND_RELEASED = 3'd2;
  localparam kind_t KIND_TIMEOUT  = 3'd3;
  localparam kind_t KIND_STATUS   = 3'd4;
  localparam kind_t KIND_BUSY     = 3'd5;

  // mode bit positions
  localparam int MODE_ALL_BIT = 0;
  localparam int MODE_CLR_BIT = 1;

  // slot table write command
  typedef struct packed {
    logic      park;
    logic      unpark;
    logic      cnt_we;
    slot_idx_t idx;
    flags_t    mask;
    mode_t     mode;
    tick_t     cnt;
  } slot_wr_t;

  // slot table read data
  typedef struct packed {
    logic   busy;
    flags_t mask;
    mode_t  mode;
    tick_t  cnt;
  } slot_rd_t;

endpackage

@@ rtl/core/evt_req_if.sv @@
// request channel interface of the event flag group
interface evt_req_if import evt_pkg::*;;
  logic      valid;
  logic      ready;
  action_t   action;
  slot_idx_t waiter;
  flags_t    mask;
  mode_t     mode;
  tick_t     timeout_ticks;

  modport source (output valid, action, waiter, mask, mode, timeout_ticks, input ready);
  modport sink   (input valid, action, waiter, mask, mode, timeout_ticks, output ready);
endinterface

@@ rtl/core/evt_rsp_if.sv @@
// result channel interface of the event flag group
interface evt_rsp_if import evt_pkg::*;;
  logic      valid;
  logic      ready;
  kind_t     kind;
  slot_idx_t waiter_id;
  flags_t    matched;
  flags_t    flags_now;
  logic      last;

  modport source (output valid, kind, waiter_id, matched, flags_now, last, input ready);
  modport sink   (input valid, kind, waiter_id, matched, flags_now, last, output ready);
endinterface

@@ rtl/core/evt_match.sv @@
// shared flag match unit: tests one mask and mode against a flag word
module evt_match import evt_pkg::*; (
  input  flags_t flags,
  input  flags_t mask,
  input  mode_t  mode,
  output flags_t hit,
  output logic   ok
);

  flags_t both;

  assign both = flags & mask;

  // all modes need every bit and report the mask, any modes need one bit
  always_comb begin
    if (mode[MODE_ALL_BIT]) begin
      hit = mask;
      ok  = (both == mask);
    end else begin
      hit = both;
      ok  = (both != '0);
    end
  end

endmodule

@@ rtl/core/evt_slots.sv @@
// waiter slot table: busy bits, masks, modes and tick countdowns
module evt_slots import evt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slot_wr_t             wr,
  input  slot_idx_t            rd_idx,
  output slot_rd_t             rd,
  output logic [WAITERS-1:0]   busy_vec
);

  logic [WAITERS-1:0] busy_r;
  flags_t             mask_r [WAITERS];
  mode_t              mode_r [WAITERS];
  tick_t              cnt_r  [WAITERS];

  // busy bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (wr.park) begin
      busy_r[wr.idx] <= 1'b1;
    end else if (wr.unpark) begin
      busy_r[wr.idx] <= 1'b0;
    end
  end

  // slot payload, written on park and on countdown update
  always_ff @(posedge clk) begin
    if (wr.park) begin
      mask_r[wr.idx] <= wr.mask;
      mode_r[wr.idx] <= wr.mode;
    end
    if (wr.park || wr.cnt_we) begin
      cnt_r[wr.idx] <= wr.cnt;
    end
  end

  // single read port at the sequencer index
  always_comb begin
    rd.busy = busy_r[rd_idx];
    rd.mask = mask_r[rd_idx];
    rd.mode = mode_r[rd_idx];
    rd.cnt  = cnt_r[rd_idx];
  end

  assign busy_vec = busy_r;

endmodule

@@ rtl/core/event_flag_group_top.sv @@
// event flag group: sequencer, flag word and output register around the slot scan
//
//   channel | dir | handshake        | payload
//   in_ch   | in  | valid/ready      | action, waiter, mask, mode, timeout_ticks
//   out_ch  | out | valid/ready      | kind, waiter_id, matched, flags_now, last
//
// One request at a time; in_ch.ready is high only while the sequencer is idle.
// Wait runs in the wait state, clear and read in the status state. Tick walks one
// slot per cycle over the single read port unless a timeout waits on out_ch; set
// makes a release and an emit pass, as every result carries the final flag word.
// Reset (synchronous, active low) clears the flag word and all busy bits.
module event_flag_group_top import evt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  evt_req_if.sink    in_ch,
  evt_rsp_if.source  out_ch
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_TICK = 3'd4;
  localparam logic [2:0] ST_STAT = 3'd5;

  localparam slot_idx_t LAST_IDX = SLOT_W'(WAITERS - 1);

  logic [2:0]         state_r, state_nxt;
  slot_idx_t          idx_r, idx_nxt;
  slot_idx_t          id_r, id_nxt;
  flags_t             mask_r, mask_nxt;
  mode_t              mode_r, mode_nxt;
  tick_t              tmo_r, tmo_nxt;
  flags_t             flag_r, flag_nxt;
  flags_t             or_word_r, or_word_nxt;
  flags_t             next_r, next_nxt;
  logic [WAITERS-1:0] rel_r, rel_nxt;

  logic      ov_r, ov_nxt;
  kind_t     okind_r;
  slot_idx_t oid_r;
  flags_t    omatched_r;
  flags_t    oflags_r;
  logic      olast_r;

  logic      emit;
  kind_t     e_kind;
  slot_idx_t e_id;
  flags_t    e_matched;
  logic      e_last;

  slot_wr_t           wr;
  slot_rd_t           rd;
  logic [WAITERS-1:0] busy_vec;

  flags_t m_flags, m_mask, m_hit;
  mode_t  m_mode;
  logic   m_ok;

  logic can_load;
  logic bad_id;
  logic active;
  logic expire;

  evt_slots u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_idx   (idx_r),
    .rd       (rd),
    .busy_vec (busy_vec)
  );

  // match unit operands: the wait tests its own mask, the set pass tests the slot
  always_comb begin
    if (state_r == ST_WAIT) begin
      m_flags = flag_r;
      m_mask  = mask_r;
      m_mode  = mode_r;
    end else begin
      m_flags = or_word_r;
      m_mask  = rd.mask;
      m_mode  = rd.mode;
    end
  end

  evt_match u_match (
    .flags (m_flags),
    .mask  (m_mask),
    .mode  (m_mode),
    .hit   (m_hit),
    .ok    (m_ok)
  );

  assign can_load    = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign bad_id      = (int'(id_r) >= WAITERS);
  assign active      = rd.busy && (rd.cnt != '0);
  assign expire      = active && (rd.cnt == tick_t'(1));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    id_nxt      = id_r;
    mask_nxt    = mask_r;
    mode_nxt    = mode_r;
    tmo_nxt     = tmo_r;
    flag_nxt    = flag_r;
    or_word_nxt = or_word_r;
    next_nxt    = next_r;
    rel_nxt     = rel_r;
    wr          = '0;
    emit        = 1'b0;
    e_kind      = KIND_STATUS;
    e_id        = '0;
    e_matched   = '0;
    e_last      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          id_nxt   = in_ch.waiter;
          mask_nxt = in_ch.mask;
          mode_nxt = in_ch.mode;
          tmo_nxt  = in_ch.timeout_ticks;
          idx_nxt  = '0;
          case (in_ch.action)
            ACT_WAIT: begin
              state_nxt = ST_WAIT;
            end
            ACT_SET: begin
              or_word_nxt = flag_r | in_ch.mask;
              next_nxt    = flag_r | in_ch.mask;
              rel_nxt     = '0;
              state_nxt   = ST_SCAN;
            end
            ACT_CLEAR: begin
              flag_nxt  = flag_r & ~in_ch.mask;
              state_nxt = ST_STAT;
            end
            ACT_TICK: begin
              state_nxt = ST_TICK;
            end
            default: begin
              state_nxt = ST_STAT;
            end
          endcase
        end
      end

      ST_WAIT: begin
        if (can_load) begin
          emit   = 1'b1;
          e_id   = id_r;
          e_last = 1'b1;
          if (bad_id || busy_vec[id_r]) begin
            e_kind = KIND_BUSY;
          end else if (m_ok) begin
            e_kind    = KIND_MATCHED;
            e_matched = m_hit;
          end else begin
            e_kind  = KIND_BLOCKED;
            wr.park = 1'b1;
            wr.idx  = id_r;
            wr.mask = mask_r;
            wr.mode = mode_r;
            wr.cnt  = tmo_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      // release pass: find satisfied waiters and build the final flag word
      ST_SCAN: begin
        if (rd.busy && m_ok) begin
          rel_nxt[idx_r] = 1'b1;
          wr.unpark      = 1'b1;
          wr.idx         = idx_r;
          if (rd.mode[MODE_CLR_BIT]) begin
            next_nxt = next_r & ~(rd.mask & mask_r);
          end
        end
        if (idx_r == LAST_IDX) begin
          flag_nxt  = next_nxt;
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // emit pass: one result per released waiter, in ascending slot order
      ST_EMIT: begin
        if (!rel_r[idx_r] || can_load) begin
          if (rel_r[idx_r]) begin
            emit      = 1'b1;
            e_kind    = KIND_RELEASED;
            e_id      = idx_r;
            e_matched = m_hit;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_STAT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      // countdown pass
      ST_TICK: begin
        if (!expire || can_load) begin
          if (active) begin
            wr.cnt_we = 1'b1;
            wr.idx    = idx_r;
            wr.cnt    = rd.cnt - 1'b1;
          end
          if (expire) begin
            wr.unpark = 1'b1;
            emit      = 1'b1;
            e_kind    = KIND_TIMEOUT;
            e_id      = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_STAT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_STAT: begin
        if (can_load) begin
          emit      = 1'b1;
          e_kind    = KIND_STATUS;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      flag_r  <= '0;
      rel_r   <= '0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      flag_r  <= flag_nxt;
      rel_r   <= rel_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // request payload and working words
  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    mask_r    <= mask_nxt;
    mode_r    <= mode_nxt;
    tmo_r     <= tmo_nxt;
    or_word_r <= or_word_nxt;
    next_r    <= next_nxt;
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      okind_r    <= e_kind;
      oid_r      <= e_id;
      omatched_r <= e_matched;
      oflags_r   <= flag_nxt;
      olast_r    <= e_last;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.kind      = okind_r;
  assign out_ch.waiter_id = oid_r;
  assign out_ch.matched   = omatched_r;
  assign out_ch.flags_now = oflags_r;
  assign out_ch.last      = olast_r;

endmodule

@@ verif/tb.sv @@
// testbench for the event flag group: random and directed requests checked against a predictor
module tb import evt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    action_t   action;
    slot_idx_t waiter;
    flags_t    mask;
    mode_t     mode;
    tick_t     timeout_ticks;
  } evt_req_t;

  typedef struct {
    kind_t     kind;
    slot_idx_t waiter_id;
    flags_t    matched;
    flags_t    flags_now;
    logic      last;
  } evt_rsp_t;

  localparam int RANDOM_REQUESTS = 103;
  localparam int DRAIN_CYCLES    = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  evt_req_if in_ch ();
  evt_rsp_if out_ch ();

  event_flag_group_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the flag word and waiter table
  flags_t    shadow_flags;
  logic      shadow_busy [WAITERS];
  flags_t    shadow_mask [WAITERS];
  mode_t     shadow_mode [WAITERS];
  tick_t     shadow_cnt  [WAITERS];

  evt_req_t  request_q [$];
  evt_rsp_t  outcome_q [$];
  int        err_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // waiter condition test; hit gets the bits that satisfy it
  function automatic logic cond_holds(input flags_t flags, input flags_t m, input mode_t md,
                                      output flags_t hit);
    if (md[MODE_ALL_BIT]) begin
      hit = m;
      return (flags & m) == m;
    end
    hit = flags & m;
    return (flags & m) != '0;
  endfunction

  function automatic void push_outcome(input kind_t kind, input int id, input flags_t matched,
                                       input logic last);
    evt_rsp_t rs;
    rs.kind      = kind;
    rs.waiter_id = slot_idx_t'(id);
    rs.matched   = matched;
    rs.flags_now = '0;
    rs.last      = last;
    outcome_q.push_back(rs);
  endfunction

  // apply one request to the shadow state and queue the results it causes
  function automatic void evaluate_request(input evt_req_t r);
    int     first;
    flags_t hit;
    flags_t nxt;
    first = outcome_q.size();
    if (r.action == ACT_WAIT) begin
      if (shadow_busy[r.waiter]) begin
        push_outcome(KIND_BUSY, int'(r.waiter), '0, 1'b1);
      end else if (cond_holds(shadow_flags, r.mask, r.mode, hit)) begin
        push_outcome(KIND_MATCHED, int'(r.waiter), hit, 1'b1);
      end else begin
        shadow_busy[r.waiter] = 1'b1;
        shadow_mask[r.waiter] = r.mask;
        shadow_mode[r.waiter] = r.mode;
        shadow_cnt[r.waiter]  = r.timeout_ticks;
        push_outcome(KIND_BLOCKED, int'(r.waiter), '0, 1'b1);
      end
    end else begin
      case (r.action)
        ACT_SET: begin
          // every test sees the word after the or, clears apply afterwards
          shadow_flags = shadow_flags | r.mask;
          nxt = shadow_flags;
          for (int i = 0; i < WAITERS; i++) begin
            if (shadow_busy[i] && cond_holds(shadow_flags, shadow_mask[i], shadow_mode[i], hit))
            begin
              shadow_busy[i] = 1'b0;
              if (shadow_mode[i][MODE_CLR_BIT]) nxt = nxt & ~(shadow_mask[i] & r.mask);
              push_outcome(KIND_RELEASED, i, hit, 1'b0);
            end
          end
          shadow_flags = nxt;
        end
        ACT_CLEAR: begin
          shadow_flags = shadow_flags & ~r.mask;
        end
        ACT_TICK: begin
          for (int i = 0; i < WAITERS; i++) begin
            if (shadow_busy[i] && shadow_cnt[i] != '0) begin
              shadow_cnt[i] = shadow_cnt[i] - 1'b1;
              if (shadow_cnt[i] == '0) begin
                shadow_busy[i] = 1'b0;
                push_outcome(KIND_TIMEOUT, i, '0, 1'b0);
              end
            end
          end
        end
        default: begin
        end
      endcase
      push_outcome(KIND_STATUS, 0, '0, 1'b1);
    end
    // every result carries the word after the whole action
    for (int i = first; i < outcome_q.size(); i++) outcome_q[i].flags_now = shadow_flags;
  endfunction

  // request driver: bursts of random length with random gaps
  int       burst_left = 1;
  int       gap_left = 0;
  evt_req_t cur_req;
  evt_req_t nxt_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur_req.action        = in_ch.action;
        cur_req.waiter        = in_ch.waiter;
        cur_req.mask          = in_ch.mask;
        cur_req.mode          = in_ch.mode;
        cur_req.timeout_ticks = in_ch.timeout_ticks;
        evaluate_request(cur_req);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          nxt_req = request_q.pop_front();
          in_ch.action        <= nxt_req.action;
          in_ch.waiter        <= nxt_req.waiter;
          in_ch.mask          <= nxt_req.mask;
          in_ch.mode          <= nxt_req.mode;
          in_ch.timeout_ticks <= nxt_req.timeout_ticks;
          in_ch.valid         <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: ready follows a rotating stall pattern reloaded after each full rotation
  logic [15:0] stall_pat = '1;
  int          pat_left = 0;
  evt_rsp_t    exp_rsp;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d id %0d", out_ch.kind,
                                    out_ch.waiter_id));
        end else begin
          exp_rsp = outcome_q.pop_front();
          if (out_ch.kind !== exp_rsp.kind || out_ch.waiter_id !== exp_rsp.waiter_id ||
              out_ch.matched !== exp_rsp.matched || out_ch.flags_now !== exp_rsp.flags_now ||
              out_ch.last !== exp_rsp.last) begin
            report_mismatch($sformatf(
              "got kind %0d id %0d matched %h flags %h last %b, exp %0d %0d %h %h %b",
              out_ch.kind, out_ch.waiter_id, out_ch.matched, out_ch.flags_now, out_ch.last,
              exp_rsp.kind, exp_rsp.waiter_id, exp_rsp.matched, exp_rsp.flags_now,
              exp_rsp.last));
          end
        end
      end
      if (pat_left == 0) begin
        pat_left = 16;
        case ($urandom_range(0, 3))
          0, 1:    stall_pat = '1;
          2:       stall_pat = 16'($urandom);
          default: stall_pat = 16'h0F0F;
        endcase
      end
      out_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      pat_left--;
    end
  end

  task automatic add_request(input action_t act, input int id, input flags_t m, input int md,
                             input tick_t tmo);
    evt_req_t r;
    r.action        = act;
    r.waiter        = slot_idx_t'(id);
    r.mask          = m;
    r.mode          = mode_t'(md);
    r.timeout_ticks = tmo;
    request_q.push_back(r);
  endtask

  function automatic flags_t sparse_bits(input int n);
    flags_t m;
    m = '0;
    repeat (n) m[$urandom_range(0, FLAG_BITS - 1)] = 1'b1;
    return m;
  endfunction

  // mostly waits on a few bits and sets that release them, with ticks in between
  function automatic evt_req_t random_request();
    evt_req_t r;
    int       sel;
    int       pick;
    sel             = $urandom_range(0, 99);
    pick            = $urandom_range(0, 9);
    r.action        = action_t'($urandom_range(0, 7));
    r.waiter        = slot_idx_t'($urandom_range(0, WAITERS - 1));
    r.mode          = mode_t'($urandom_range(0, 3));
    r.mask          = flags_t'($urandom);
    r.timeout_ticks = tick_t'($urandom);
    if (sel < 40) begin
      r.action = ACT_WAIT;
      if (pick == 0) r.mask = '0;
      else if (pick > 2) r.mask = sparse_bits($urandom_range(1, 3));
      pick = $urandom_range(0, 9);
      if (pick < 2) r.timeout_ticks = '0;
      else if (pick > 2) r.timeout_ticks = tick_t'($urandom_range(1, 5));
    end else if (sel < 60) begin
      r.action = ACT_SET;
      if (pick > 1) r.mask = sparse_bits($urandom_range(1, 3));
    end else if (sel < 80) begin
      r.action = ACT_TICK;
    end else if (sel < 88) begin
      r.action = ACT_CLEAR;
      if (pick > 4) r.mask = sparse_bits($urandom_range(1, 4));
    end else if (sel < 95) begin
      r.action = ACT_READ;
    end else begin
      r.action = action_t'($urandom_range(5, 7));
    end
    return r;
  endfunction

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_READ;
    in_ch.waiter        = '0;
    in_ch.mask          = '0;
    in_ch.mode          = '0;
    in_ch.timeout_ticks = '0;
    out_ch.ready        = 1'b0;
    shadow_flags = '0;
    for (int i = 0; i < WAITERS; i++) begin
      shadow_busy[i] = 1'b0;
      shadow_mask[i] = '0;
      shadow_mode[i] = '0;
      shadow_cnt[i]  = '0;
    end

    // directed: empty masks, busy slot, timeouts, clear modes, matched-now without clearing
    add_request(ACT_READ,  0, '0,       0, '0);
    add_request(ACT_WAIT,  0, '0,       0, 16'd2);
    add_request(ACT_WAIT,  1, '0,       1, '0);
    add_request(ACT_WAIT,  0, '1,       1, '0);
    add_request(ACT_TICK,  0, '0,       0, '0);
    add_request(ACT_TICK,  0, '0,       0, '0);
    add_request(ACT_WAIT,  2, 16'h00F0, 3, '0);
    add_request(ACT_WAIT,  3, 16'h0011, 2, 16'd5);
    add_request(ACT_WAIT,  4, 16'h8000, 0, '1);
    add_request(ACT_WAIT,  5, '1,       1, 16'd1);
    add_request(ACT_SET,   0, 16'h0031, 0, '0);
    add_request(ACT_TICK,  0, '0,       0, '0);
    add_request(ACT_SET,   0, '1,       0, '0);
    add_request(ACT_WAIT,  6, 16'h0F00, 2, '0);
    add_request(ACT_WAIT,  7, 16'h000F, 3, '0);
    add_request(ACT_CLEAR, 0, '1,       0, '0);
    add_request(action_t'(3'd7), 5, '1, 3, '1);
    // every slot parked on one bit, then a single set releases them all in order
    for (int i = 0; i < WAITERS; i++) begin
      add_request(ACT_WAIT, i, 16'h0001, i % 4, (i % 2 == 0) ? tick_t'('0) : tick_t'('1));
    end
    add_request(ACT_SET,   0, 16'h0001, 0, '0);
    add_request(ACT_READ,  0, '0,       0, '0);

    repeat (RANDOM_REQUESTS) request_q.push_back(random_request());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/evt_pkg.sv
rtl/core/evt_req_if.sv
rtl/core/evt_rsp_if.sv
rtl/core/evt_match.sv
rtl/core/evt_slots.sv
rtl/core/event_flag_group_top.sv
verif/tb.sv
